/* hw/rtl/hrse_pkg.sv */
// Shared types and pipeline constants for the HDR pixel scale encoder.
package hrse_pkg;

  localparam int CHAN_W     = 16;
  localparam int CODE_W     = 8;
  localparam int NORM_W     = 17;
  localparam int LANES      = 3;
  localparam int CODE_STEPS = 8;   // one quotient bit of the scale code per stage
  localparam int NORM_STEPS = 17;  // one quotient bit of a norm per stage
  localparam int NUM_W      = 24;  // max*255 + limit - 1, and code*limit
  localparam int REM_W      = 40;  // channel*255*65536
  localparam int PREP_STAGES = 2;
  localparam int LANE_STAGES = NORM_STEPS + 1;
  localparam int PIPE_STAGES = PREP_STAGES + CODE_STEPS + LANE_STAGES;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [LANES-1:0] trio_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [NORM_W-1:0] norm_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [REM_W-1:0]  rem_t;

  typedef struct packed {
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
  } pix_in_t;

  typedef struct packed {
    norm_t red_norm;
    norm_t green_norm;
    norm_t blue_norm;
    code_t scale_code;
  } pix_out_t;

  // What the scale-code divider hands to the lanes
  typedef struct packed {
    trio_t chans;
    logic  blk;
    code_t code;
  } scaled_t;

endpackage

/* hw/rtl/hrse_prep.sv */
// Clamp stage and max/numerator stage ahead of the scale-code divider.
module hrse_prep (
  input  logic            clk,
  input  logic            en,
  input  hrse_pkg::pix_in_t pixel,
  input  hrse_pkg::chan_t limit,
  output hrse_pkg::trio_t chans,
  output hrse_pkg::num_t  num,
  output logic            blk
);
  import hrse_pkg::*;

  trio_t clamped;
  chan_t mx;
  chan_t mx_rg;

  // Stage 0: clamp each channel to the overbright limit
  always_ff @(posedge clk) begin
    if (en) begin
      clamped[0] <= (pixel.red_in   < limit) ? pixel.red_in   : limit;
      clamped[1] <= (pixel.green_in < limit) ? pixel.green_in : limit;
      clamped[2] <= (pixel.blue_in  < limit) ? pixel.blue_in  : limit;
    end
  end

  // Largest clamped channel
  assign mx_rg = (clamped[1] > clamped[0]) ? clamped[1] : clamped[0];
  assign mx    = (clamped[2] > mx_rg) ? clamped[2] : mx_rg;

  // Stage 1: ceiling numerator max*255 + limit - 1, black flag
  always_ff @(posedge clk) begin
    if (en) begin
      chans <= clamped;
      num   <= ({mx, 8'h00} - {8'h00, mx}) + NUM_W'(limit) - NUM_W'(1);
      blk   <= (mx == '0);
    end
  end

endmodule

/* hw/rtl/hrse_code_div.sv */
// Pipelined restoring divider for the eight-bit scale code, one bit per stage.
module hrse_code_div (
  input  logic            clk,
  input  logic            en,
  input  hrse_pkg::trio_t chans,
  input  hrse_pkg::num_t  num,
  input  logic            blk,
  input  hrse_pkg::chan_t limit,
  output hrse_pkg::scaled_t scaled
);
  import hrse_pkg::*;

  num_t  rem   [CODE_STEPS];
  code_t quo   [CODE_STEPS];
  trio_t chs   [CODE_STEPS];
  logic  blks  [CODE_STEPS];

  for (genvar j = 0; j < CODE_STEPS; j++) begin : g_step
    localparam int BIT = CODE_STEPS - 1 - j;
    num_t  rem_src;
    code_t quo_src;
    trio_t chs_src;
    logic  blk_src;
    num_t  divisor;
    logic  fits;
    code_t quo_next;

    if (j == 0) begin : g_first
      assign rem_src = num;
      assign quo_src = '0;
      assign chs_src = chans;
      assign blk_src = blk;
    end else begin : g_rest
      assign rem_src = rem[j-1];
      assign quo_src = quo[j-1];
      assign chs_src = chs[j-1];
      assign blk_src = blks[j-1];
    end

    // Try the limit shifted to this quotient bit
    assign divisor = NUM_W'(limit) << BIT;
    assign fits    = (rem_src >= divisor);

    always_comb begin
      quo_next      = quo_src;
      quo_next[BIT] = fits;
    end

    // Advance remainder, quotient and the carried pixel
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= fits ? (rem_src - divisor) : rem_src;
        quo[j]  <= quo_next;
        chs[j]  <= chs_src;
        blks[j] <= blk_src;
      end
    end
  end

  assign scaled.chans = chs[CODE_STEPS-1];
  assign scaled.blk   = blks[CODE_STEPS-1];
  assign scaled.code  = quo[CODE_STEPS-1];

endmodule

/* hw/rtl/hrse_norm_lane.sv */
// One channel lane: divisor product, then a 17-stage restoring divider for the norm.
module hrse_norm_lane (
  input  logic            clk,
  input  logic            en,
  input  hrse_pkg::chan_t chan,
  input  hrse_pkg::code_t code,
  input  hrse_pkg::chan_t limit,
  output hrse_pkg::norm_t norm
);
  import hrse_pkg::*;

  num_t  dvs;
  rem_t  rem0;
  rem_t  rem [NORM_STEPS];
  norm_t quo [NORM_STEPS];
  num_t  dv  [NORM_STEPS];

  // Product stage: denominator code*limit, numerator channel*255*65536
  always_ff @(posedge clk) begin
    if (en) begin
      dvs  <= NUM_W'(code) * NUM_W'(limit);
      rem0 <= {({chan, 8'h00} - {8'h00, chan}), 16'h0000};
    end
  end

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_step
    localparam int BIT = NORM_STEPS - 1 - j;
    rem_t  rem_src;
    norm_t quo_src;
    num_t  dv_src;
    rem_t  divisor;
    logic  fits;
    norm_t quo_next;

    if (j == 0) begin : g_first
      assign rem_src = rem0;
      assign quo_src = '0;
      assign dv_src  = dvs;
    end else begin : g_rest
      assign rem_src = rem[j-1];
      assign quo_src = quo[j-1];
      assign dv_src  = dv[j-1];
    end

    assign divisor = REM_W'(dv_src) << BIT;
    assign fits    = (rem_src >= divisor);

    always_comb begin
      quo_next      = quo_src;
      quo_next[BIT] = fits;
    end

    // Advance one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= fits ? (rem_src - divisor) : rem_src;
        quo[j] <= quo_next;
        dv[j]  <= dv_src;
      end
    end
  end

  assign norm = quo[NORM_STEPS-1];

endmodule

/* hw/rtl/hdr_pixel_rgb_scale_encoder.sv */
// Top level of the HDR pixel scale encoder: pipeline control, lanes and result merge.
// Takes one Q8.8 RGB pixel per cycle unless pixel_stall is high, and gives an
// eight-bit shared scale code plus three Q1.16 channel norms. A pixel passes the
// two prep stages, the eight-stage scale-code divider and the eighteen-stage norm
// lanes (one product stage and a 17-stage divider each) to the result register.
// A two-word output buffer lets the pipeline keep taking pixels while a result
// waits; pixel_stall rises only once both words are held. The overbright limit
// (reset 4096, i.e. 16.0) is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while no pixel is in flight: the block does not enforce it.
module hdr_pixel_rgb_scale_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  hrse_pkg::pix_in_t  pixel,
  output logic               result_valid,
  input  logic               result_stall,
  output hrse_pkg::pix_out_t result,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);
  import hrse_pkg::*;

  typedef struct packed {
    logic  blk;
    code_t code;
  } side_t;

  chan_t    overbright_limit;
  logic     vld [PIPE_STAGES];
  logic     adv;
  trio_t    prep_chans;
  num_t     prep_num;
  logic     prep_blk;
  scaled_t  scaled;
  norm_t    norms [LANES];
  side_t    side [LANE_STAGES];
  pix_out_t merged;
  pix_out_t skid;
  logic     skid_vld;
  logic     take;
  logic     push;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      overbright_limit <= 16'd4096;
    end else if (cfg_wr_en) begin
      overbright_limit <= cfg_wr_data;
    end
  end

  // Pipeline moves as a whole unless the output buffer is full
  assign adv         = !skid_vld;
  assign pixel_stall = skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_STAGES; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= pixel_valid;
      for (int i = 1; i < PIPE_STAGES; i++) vld[i] <= vld[i-1];
    end
  end

  hrse_prep u_prep (
    .clk   (clk),
    .en    (adv),
    .pixel (pixel),
    .limit (overbright_limit),
    .chans (prep_chans),
    .num   (prep_num),
    .blk   (prep_blk)
  );

  hrse_code_div u_code (
    .clk    (clk),
    .en     (adv),
    .chans  (prep_chans),
    .num    (prep_num),
    .blk    (prep_blk),
    .limit  (overbright_limit),
    .scaled (scaled)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    hrse_norm_lane u_lane (
      .clk   (clk),
      .en    (adv),
      .chan  (scaled.chans[l]),
      .code  (scaled.code),
      .limit (overbright_limit),
      .norm  (norms[l])
    );
  end

  // Carry code and black flag alongside the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{blk: scaled.blk, code: scaled.code};
      for (int i = 1; i < LANE_STAGES; i++) side[i] <= side[i-1];
    end
  end

  // Merge the lanes; force a black pixel to all zeros
  always_comb begin
    if (side[LANE_STAGES-1].blk) begin
      merged = '0;
    end else begin
      merged.red_norm   = norms[0];
      merged.green_norm = norms[1];
      merged.blue_norm  = norms[2];
      merged.scale_code = side[LANE_STAGES-1].code;
    end
  end

  // Output register plus skid word
  assign take = result_valid && !result_stall;
  assign push = adv && vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_vld     <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        skid_vld <= 1'b0;
      end
    end else if (push) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) begin
        result <= skid;
      end
    end else if (push) begin
      if (!result_valid || take) begin
        result <= merged;
      end else begin
        skid <= merged;
      end
    end
  end

endmodule

/* hw/rtl/hrse_checker.sv */
// Port-level checks for the HDR pixel scale encoder, bound to the top level.
module hrse_checker (
  input logic               clk,
  input logic               rst,
  input logic               pixel_stall,
  input logic               result_valid,
  input logic               result_stall,
  input hrse_pkg::pix_out_t result
);
  import hrse_pkg::*;

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed or dropped");

  // Stall the input only while a result word is waiting
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid)
    else $error("input stalled with no result waiting");

  // Black pixel gives all-zero norms
  a_black: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.scale_code == '0) |->
      (result.red_norm == '0) && (result.green_norm == '0) && (result.blue_norm == '0))
    else $error("black pixel with nonzero norm");

  // A lit pixel has at least one nonzero norm
  a_lit: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.scale_code != '0) |->
      (result.red_norm != '0) || (result.green_norm != '0) || (result.blue_norm != '0))
    else $error("lit pixel with all norms zero");

  // Norms never exceed 1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.red_norm <= 17'd65536) && (result.green_norm <= 17'd65536) &&
      (result.blue_norm <= 17'd65536))
    else $error("norm above 1.0");

endmodule

bind hdr_pixel_rgb_scale_encoder hrse_checker u_hrse_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

/* sim/tb_top.sv */
// Self-checking testbench for the HDR pixel scale encoder.
`timescale 1ns / 1ps

module tb_top;
  import hrse_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  pix_in_t     pixel = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  pix_out_t    result;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // Words waiting to be offered, and results the encoder still owes
  pix_in_t     pixel_backlog[$];
  pix_out_t    pending_results[$];
  logic [15:0] overbright_q88 = 16'd4096;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          errors_seen = 0;
  int          cycles = 0;
  int          hold_left = 0;
  logic        hold_go = 1'b0;

  hdr_pixel_rgb_scale_encoder u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Clamp, pick the shared scale code, then divide each channel by the decoded scale
  function automatic pix_out_t encode_pixel(pix_in_t px, logic [15:0] lim);
    longint unsigned chan [3];
    longint unsigned norms [3];
    longint unsigned peak;
    longint unsigned code;
    longint unsigned denom;
    longint unsigned lim_w;
    pix_out_t res;
    lim_w = lim;
    chan[0] = (px.red_in < lim) ? px.red_in : lim;
    chan[1] = (px.green_in < lim) ? px.green_in : lim;
    chan[2] = (px.blue_in < lim) ? px.blue_in : lim;
    peak = chan[0];
    if (chan[1] > peak) peak = chan[1];
    if (chan[2] > peak) peak = chan[2];
    res = '0;
    // black pixel or zero limit: everything stays zero
    if (peak != 0 && lim_w != 0) begin
      code = (peak * 255 + lim_w - 1) / lim_w;
      if (code > 255) code = 255;
      if (code == 0) code = 1;
      denom = code * lim_w;
      for (int i = 0; i < 3; i++) begin
        norms[i] = (chan[i] * 255 * 65536) / denom;
        if (norms[i] > 65536) norms[i] = 65536;
      end
      res.red_norm   = norm_t'(norms[0]);
      res.green_norm = norm_t'(norms[1]);
      res.blue_norm  = norm_t'(norms[2]);
      res.scale_code = code_t'(code);
    end
    return res;
  endfunction

  // Full-range noise, in-range values, values around the limit, small values and zeros
  function automatic chan_t pick_channel(logic [15:0] lim);
    int kind;
    int v;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: v = $urandom_range(65535);
      4, 5, 6: v = $urandom_range(lim, 0);
      7: begin
        v = int'(lim) + $urandom_range(4) - 2;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      8: v = $urandom_range(15);
      default: v = 0;
    endcase
    return chan_t'(v);
  endfunction

  task automatic queue_pixel(int r, int g, int b);
    pix_in_t px;
    px.red_in   = chan_t'(r);
    px.green_in = chan_t'(g);
    px.blue_in  = chan_t'(b);
    pixel_backlog.push_back(px);
  endtask

  task automatic queue_random(int count);
    pix_in_t px;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) begin
        px = '0;
      end else begin
        px.red_in   = pick_channel(overbright_q88);
        px.green_in = pick_channel(overbright_q88);
        px.blue_in  = pick_channel(overbright_q88);
      end
      pixel_backlog.push_back(px);
    end
  endtask

  task automatic write_limit(logic [15:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    overbright_q88 = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every word is sent and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || pixel_valid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Offer pixels; hold a stalled word, predict each accepted one
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall)
        pending_results.push_back(encode_pixel(pixel, overbright_q88));
      if (!pixel_valid || !pixel_stall) begin
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          pixel_valid <= 1'b1;
          pixel       <= pixel_backlog.pop_front();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    pix_out_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          errors_seen++;
          if (errors_seen <= 10)
            $display("ERROR: unexpected result word code=%0d r=%0d g=%0d b=%0d",
                     result.scale_code, result.red_norm, result.green_norm,
                     result.blue_norm);
        end else begin
          want = pending_results.pop_front();
          if (result.red_norm !== want.red_norm || result.green_norm !== want.green_norm ||
              result.blue_norm !== want.blue_norm ||
              result.scale_code !== want.scale_code) begin
            errors_seen++;
            if (errors_seen <= 10)
              $display("ERROR: expected code=%0d r=%0d g=%0d b=%0d, got code=%0d r=%0d g=%0d b=%0d",
                       want.scale_code, want.red_norm, want.green_norm, want.blue_norm,
                       result.scale_code, result.red_norm, result.green_norm,
                       result.blue_norm);
          end
        end
      end
      result_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] limits [8];
    int          counts [8];
    int          mode;
    limits = '{16'd65535, 16'd1, 16'd0, 16'd300, 16'd4096, 16'd0, 16'd256, 16'd40000};
    counts = '{260, 260, 60, 260, 260, 260, 260, 260};
    limits[5] = 16'($urandom_range(65535, 1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset limit of 16.0
    queue_pixel(0, 0, 0);
    queue_pixel(65535, 65535, 65535);
    queue_pixel(4096, 0, 0);
    queue_pixel(4097, 4095, 1);
    queue_pixel(1, 0, 0);
    queue_pixel(0, 1, 0);
    queue_pixel(0, 0, 1);
    queue_pixel(100, 3000, 200);
    queue_pixel(7, 9, 2048);
    queue_pixel(1234, 1234, 1234);
    queue_pixel(32768, 0, 16);
    queue_pixel(16, 17, 15);
    queue_pixel(4080, 4081, 4079);
    queue_pixel(65535, 0, 0);
    queue_pixel(0, 65535, 2);
    queue_pixel(21845, 43690, 255);
    queue_pixel(2, 3, 1);
    queue_pixel(4096, 4096, 0);
    queue_pixel(61680, 3855, 52428);
    queue_pixel(13107, 65280, 255);
    wait_drained();

    // Random phases over limits and idling modes
    for (int ph = 0; ph < 8; ph++) begin
      write_limit(limits[ph]);
      mode = ph % 4;
      sender_idle_pct = (mode == 1) ? 47 : (mode == 3) ? 28 : 0;
      stall_pct       = (mode == 2) ? 47 : (mode == 3) ? 28 : 0;
      if (ph == 4) begin
        // hold the output back while pixels keep coming, so the input backs up
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      queue_random(counts[ph]);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors_seen == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
